// ----- rtl/core/pcg32_pkg.sv -----
// Shared definitions for the PCG32 generator core: codes, control word layout
// and the microcode program. No dependencies.
`timescale 1ns / 1ps

package pcg32_pkg;

    // LCG multiplier and the state after reset (seeded with zero)
    localparam logic [63:0] LCG_MULT      = 64'h5851_f42d_4c95_7f2d;
    localparam logic [63:0] STATE_RESET   = 64'h5851_f42d_4c95_7f2e;
    localparam logic [63:0] INC_RESET     = 64'h0000_0000_0000_0001;

    // Output permutation geometry
    localparam int unsigned ROT_LSB   = 59;
    localparam int unsigned XS_SHIFT  = 18;
    localparam int unsigned MIX_LSB   = 27;

    // Transaction modes
    localparam logic [1:0] MODE_RESEED  = 2'd0;
    localparam logic [1:0] MODE_RAW     = 2'd1;
    localparam logic [1:0] MODE_BOUNDED = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // Multiplier operand selects
    localparam logic [1:0] MS_LL = 2'd0;   // lo(state) * lo(mult), full product
    localparam logic [1:0] MS_HL = 2'd1;   // hi(state) * lo(mult), low half used
    localparam logic [1:0] MS_LH = 2'd2;   // lo(state) * hi(mult), low half used

    // Accumulator operations
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_LOAD  = 2'd1;
    localparam logic [1:0] ACC_ADDHI = 2'd2;

    // State operations
    localparam logic [1:0] ST_HOLD    = 2'd0;
    localparam logic [1:0] ST_STEP    = 2'd1;  // state = acc + increment
    localparam logic [1:0] ST_CLEAR   = 2'd2;  // state = 0, increment from seed
    localparam logic [1:0] ST_ADDSEED = 2'd3;  // state += seed

    // Divider operations
    localparam logic [1:0] DV_HOLD = 2'd0;
    localparam logic [1:0] DV_INIT = 2'd1;
    localparam logic [1:0] DV_STEP = 2'd2;

    // Sequencer jumps
    localparam logic [2:0] J_NEXT      = 3'd0;
    localparam logic [2:0] J_DONE_NONE = 3'd1;  // finish, no result
    localparam logic [2:0] J_RAWCHK    = 3'd2;  // raw or bound zero: emit draw
    localparam logic [2:0] J_LOOP      = 3'd3;  // repeat while bits remain
    localparam logic [2:0] J_CHECK     = 3'd4;  // accept remainder or redraw

    localparam int unsigned PC_W = 5;

    localparam logic [PC_W-1:0] PC_RESEED = 5'd0;
    localparam logic [PC_W-1:0] PC_DRAW   = 5'd12;
    localparam logic [PC_W-1:0] PC_DIV    = 5'd18;
    localparam logic [PC_W-1:0] PC_LAST   = 5'd19;

    typedef struct packed {
        logic [1:0]      mul_sel;
        logic [1:0]      acc_op;
        logic [1:0]      st_op;
        logic            x_load;
        logic [1:0]      div_op;
        logic [2:0]      jmp;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    function automatic ctrl_word_t cw(input logic [1:0] mul_sel, input logic [1:0] acc_op,
                                      input logic [1:0] st_op, input logic x_load,
                                      input logic [1:0] div_op, input logic [2:0] jmp,
                                      input logic [PC_W-1:0] target);
        ctrl_word_t w;
        w.mul_sel = mul_sel;
        w.acc_op  = acc_op;
        w.st_op   = st_op;
        w.x_load  = x_load;
        w.div_op  = div_op;
        w.jmp     = jmp;
        w.target  = target;
        return w;
    endfunction

    // Microcode program: reseed at PC_RESEED, draw at PC_DRAW
    function automatic ctrl_word_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        unique case (pc)
            // reseed: clear, advance, add seed, advance
            5'd0:  w = cw(MS_LL, ACC_HOLD,  ST_CLEAR,   1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd1:  w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd2:  w = cw(MS_HL, ACC_LOAD,  ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd3:  w = cw(MS_LH, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd4:  w = cw(MS_LL, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd5:  w = cw(MS_LL, ACC_HOLD,  ST_STEP,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd6:  w = cw(MS_LL, ACC_HOLD,  ST_ADDSEED, 1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd7:  w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd8:  w = cw(MS_HL, ACC_LOAD,  ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd9:  w = cw(MS_LH, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd10: w = cw(MS_LL, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_RESEED);
            5'd11: w = cw(MS_LL, ACC_HOLD,  ST_STEP,    1'b0, DV_HOLD, J_DONE_NONE, PC_RESEED);
            // draw: capture output, advance, then bounded reduction
            5'd12: w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b1, DV_HOLD, J_NEXT,      PC_DRAW);
            5'd13: w = cw(MS_HL, ACC_LOAD,  ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_DRAW);
            5'd14: w = cw(MS_LH, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_DRAW);
            5'd15: w = cw(MS_LL, ACC_ADDHI, ST_HOLD,    1'b0, DV_HOLD, J_NEXT,      PC_DRAW);
            5'd16: w = cw(MS_LL, ACC_HOLD,  ST_STEP,    1'b0, DV_HOLD, J_RAWCHK,    PC_DRAW);
            5'd17: w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b0, DV_INIT, J_NEXT,      PC_DRAW);
            5'd18: w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b0, DV_STEP, J_LOOP,      PC_DIV);
            5'd19: w = cw(MS_LL, ACC_HOLD,  ST_HOLD,    1'b0, DV_HOLD, J_CHECK,     PC_DRAW);
            default: w = cw(MS_LL, ACC_HOLD, ST_HOLD,   1'b0, DV_HOLD, J_DONE_NONE, PC_RESEED);
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/pcg32_generator_with_bounded_draw_core.sv -----
// PCG32 XSH-RR generator core with raw and bounded draws, run by a microcode
// sequencer over a shared 32x32 multiplier and a bit-serial remainder unit.
// Depends on pcg32_pkg.
`timescale 1ns / 1ps

//  channel   signals                       direction   transaction
//  in        in_valid in_ready mode bound  to core     one request (reseed/raw/bounded)
//  out       out_valid out_ready value     from core   one 32-bit draw
//  cfg       cfg_we cfg_wdata              to core     seed register write
//
// A raw draw captures the output and steps the LCG on the shared multiplier. A
// bounded draw adds, per attempt, a divider start, the one-bit-per-cycle
// remainder and the rejection test; a rejected attempt repeats. in_ready is high
// whenever the sequencer is idle, also while a result waits on out. A finished
// draw stalls the sequencer only when the output register is still full. Reset
// gives the zero-seeded state.

module pcg32_generator_with_bounded_draw_core
    import pcg32_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] bound,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] value,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata
);

    logic [63:0]     seed_reg;
    logic [63:0]     state_reg;
    logic [63:0]     inc_reg;
    logic [63:0]     acc_reg;
    logic [63:0]     prod_reg;
    logic [31:0]     x_reg;
    logic [31:0]     dvd_reg;
    logic [31:0]     rem_reg;
    logic [4:0]      cnt_reg;
    logic [31:0]     bound_reg;
    logic            is_bnd_reg;
    logic            busy_reg;
    logic            busy_next;
    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     value_reg;
    logic [31:0]     value_next;

    ctrl_word_t  cw_cur;
    logic        in_fire;
    logic        out_free;
    logic        emit_req;
    logic        step_en;
    logic [31:0] emit_val;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mixed;
    logic [4:0]  rot;
    logic [63:0] rot2;
    logic [31:0] perm;
    logic [32:0] trial;
    logic [32:0] trial_sub;
    logic        accept_r;

    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign cw_cur = ucode_rom(pc_reg);

    // XSH-RR output of the current state
    assign rot   = state_reg[63:ROT_LSB];
    assign mixed = 32'((state_reg ^ (state_reg >> XS_SHIFT)) >> MIX_LSB);
    assign rot2  = {mixed, mixed} >> rot;
    assign perm  = rot2[31:0];

    // Shared multiplier operands
    always_comb
    begin
        unique case (cw_cur.mul_sel)
            MS_HL:
            begin
                mul_a = state_reg[63:32];
                mul_b = LCG_MULT[31:0];
            end
            MS_LH:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[63:32];
            end
            default:
            begin
                mul_a = state_reg[31:0];
                mul_b = LCG_MULT[31:0];
            end
        endcase
    end

    // One restoring remainder step and the rejection test
    assign trial     = {rem_reg, dvd_reg[31]};
    assign trial_sub = trial - {1'b0, bound_reg};
    assign accept_r  = (x_reg - rem_reg) <= (32'd0 - bound_reg);

    // Sequencer: next step, result hand-off and stall
    always_comb
    begin
        pc_next        = pc_reg;
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg && !out_ready;
        value_next     = value_reg;
        emit_req       = 1'b0;
        emit_val       = x_reg;
        if (busy_reg)
        begin
            unique case (cw_cur.jmp)
                J_DONE_NONE:
                    busy_next = 1'b0;
                J_RAWCHK:
                    if (!is_bnd_reg || bound_reg == 32'd0)
                        emit_req = 1'b1;
                    else
                        pc_next = pc_reg + 1'b1;
                J_LOOP:
                    if (cnt_reg != 5'd0)
                        pc_next = cw_cur.target;
                    else
                        pc_next = pc_reg + 1'b1;
                J_CHECK:
                    if (accept_r)
                    begin
                        emit_req = 1'b1;
                        emit_val = rem_reg;
                    end
                    else
                        pc_next = cw_cur.target;
                default:
                    pc_next = pc_reg + 1'b1;
            endcase
            // Hold the step while the output register is still full
            if (emit_req)
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = emit_val;
                    busy_next      = 1'b0;
                end
                else
                    pc_next = pc_reg;
            end
        end
        else if (in_fire)
        begin
            busy_next = (mode != MODE_UNUSED);
            pc_next   = (mode == MODE_RESEED) ? PC_RESEED : PC_DRAW;
        end
    end

    assign step_en = busy_reg && !(emit_req && !out_free);

    // Control registers and generator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            pc_reg        <= PC_RESEED;
            out_valid_reg <= 1'b0;
            seed_reg      <= 64'd0;
            state_reg     <= STATE_RESET;
            inc_reg       <= INC_RESET;
        end
        else
        begin
            busy_reg      <= busy_next;
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
                seed_reg <= cfg_wdata;
            if (step_en)
            begin
                unique case (cw_cur.st_op)
                    ST_STEP:    state_reg <= acc_reg + inc_reg;
                    ST_CLEAR:
                    begin
                        state_reg <= 64'd0;
                        inc_reg   <= {seed_reg[62:0], 1'b1};
                    end
                    ST_ADDSEED: state_reg <= state_reg + seed_reg;
                    default:    state_reg <= state_reg;
                endcase
            end
        end
    end

    // Datapath payload: product, accumulator, draw, remainder, result
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prod_reg  <= 64'(mul_a) * 64'(mul_b);
        if (in_fire)
        begin
            bound_reg  <= bound;
            is_bnd_reg <= (mode == MODE_BOUNDED);
        end
        if (step_en)
        begin
            unique case (cw_cur.acc_op)
                ACC_LOAD:  acc_reg <= prod_reg;
                ACC_ADDHI: acc_reg <= {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                default:   acc_reg <= acc_reg;
            endcase
            if (cw_cur.x_load)
                x_reg <= perm;
            unique case (cw_cur.div_op)
                DV_INIT:
                begin
                    dvd_reg <= x_reg;
                    rem_reg <= 32'd0;
                    cnt_reg <= 5'd31;
                end
                DV_STEP:
                begin
                    dvd_reg <= {dvd_reg[30:0], 1'b0};
                    rem_reg <= trial_sub[32] ? trial[31:0] : trial_sub[31:0];
                    cnt_reg <= cnt_reg - 1'b1;
                end
                default:
                begin
                    dvd_reg <= dvd_reg;
                end
            endcase
        end
    end

    // Stream increment stays odd
    a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n) inc_reg[0])
        else $error("stream increment became even");

    // Sequencer never leaves the program
    a_pc_range: assert property (@(posedge clk) disable iff (!rst_n) pc_reg <= PC_LAST)
        else $error("step counter outside microcode");

    // A bounded result is below its bound
    a_bnd_below: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && emit_req && out_free && cw_cur.jmp == J_CHECK)
            |=> (value_reg < bound_reg))
        else $error("bounded draw not below bound");

    // An accepted request other than the unused mode starts the sequencer
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && mode != MODE_UNUSED) |=> busy_reg)
        else $error("accepted transaction did not start");

endmodule
